// ===== src/length_prefixed_request_deframer_macros.svh =====
// Assertion macros used by the deframer checker
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled in reset
`define LPRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LPRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lprd_pkg.sv =====
// Types and constants of the length-prefixed request deframer
`timescale 1ns / 1ps
package lprd_pkg;

  localparam logic [15:0] MaxMsgReset  = 16'd4096;
  localparam logic [7:0]  MaxArgsReset = 8'd16;
  localparam logic [15:0] HdrBytes     = 16'd4;

  typedef enum logic [0:0] {
    CFG_MAX_MSG  = 1'b0,
    CFG_MAX_ARGS = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_LEN    = 2'd0,
    PH_COUNT  = 2'd1,
    PH_ARGLEN = 2'd2,
    PH_BODY   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ARG_BYTE  = 2'd0,
    KIND_EMPTY_ARG = 2'd1,
    KIND_EMPTY_REQ = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    FAULT_TOO_LONG      = 3'd0,
    FAULT_UNDER_MIN     = 3'd1,
    FAULT_TOO_MANY_ARGS = 3'd2,
    FAULT_HDR_OVERRUN   = 3'd3,
    FAULT_BODY_OVERRUN  = 3'd4,
    FAULT_TRAILING      = 3'd5
  } fault_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [7:0] arg_index;
    logic       arg_last;
    logic       message_last;
    fault_e     fault_code;
  } result_t;

endpackage

// ===== src/length_prefixed_request_deframer.sv =====
// Top level of the length-prefixed request deframer
`timescale 1ns / 1ps
// Takes one stream byte per clock cycle while the result side is ready and
// returns at most one result beat per byte: the byte is first held in the
// input register, then the decode updates the framing counters and loads the
// result register. Both registers pass a beat on in the same cycle they take
// a new one, so a steady byte stream runs at one byte per cycle whenever the
// result side is ready. After an error beat the block drops all further bytes
// until reset. Write the limit registers only while no bytes are in flight.
module length_prefixed_request_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [15:8] arg_index, [16] arg_last, [19:17] fault_code
  output logic [23:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // [1:0] item_kind
  output logic        m_axis_tlast   // message_last
);

  logic              in_vld;
  logic [7:0]        in_byte;
  logic              can_load;
  logic              advance;
  lprd_pkg::result_t res;

  assign advance = in_vld && can_load;

  lprd_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance_i     (advance),
    .valid_o       (in_vld),
    .byte_o        (in_byte)
  );

  lprd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .byte_i      (in_byte),
    .res_o       (res)
  );

  lprd_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .advance_i     (advance),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== src/lprd_in_stage.sv =====
// Input beat register of the deframer
`timescale 1ns / 1ps
module lprd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       take;

  assign s_axis_tready = !vld_q || advance_i;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign vld_d         = take ? 1'b1 : (advance_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= s_axis_tdata;
    end
  end

  assign valid_o = vld_q;
  assign byte_o  = byte_q;

endmodule

// ===== src/lprd_core.sv =====
// Framing state, configuration registers and per-byte decode of the deframer
`timescale 1ns / 1ps
module lprd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output lprd_pkg::result_t res_o
);

  logic [15:0]      max_msg_q;
  logic [7:0]       max_args_q;

  lprd_pkg::phase_e phase_q, phase_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [31:0]      shift_q, shift_d;
  logic [15:0]      rem_q, rem_d;
  logic [7:0]       args_left_q, args_left_d;
  logic [15:0]      abl_q, abl_d;
  logic [7:0]       cur_q, cur_d;
  logic             dead_q, dead_d;

  logic [31:0]      shift_new;
  logic [15:0]      rem_dec;
  logic [15:0]      body_abl;
  logic             body_alast;
  logic [7:0]       args_dec;
  logic [15:0]      post;
  logic             hdr_done;
  logic             err;
  lprd_pkg::fault_e fault;
  lprd_pkg::result_t res;

  assign shift_new  = shift_q | ({24'd0, byte_i} << {cnt_q, 3'b000});
  assign rem_dec    = rem_q - 16'd1;
  assign body_abl   = abl_q - 16'd1;
  assign body_alast = (body_abl == 16'd0);
  assign args_dec   = args_left_q - 8'd1;
  assign post       = rem_dec - shift_new[15:0];
  assign hdr_done   = (cnt_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q  <= lprd_pkg::MaxMsgReset;
      max_args_q <= lprd_pkg::MaxArgsReset;
    end else if (cfg_we_i) begin
      unique case (lprd_pkg::cfg_idx_e'(cfg_idx_i))
        lprd_pkg::CFG_MAX_MSG:  max_msg_q  <= cfg_wdata_i;
        lprd_pkg::CFG_MAX_ARGS: max_args_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    err   = 1'b0;
    fault = lprd_pkg::FAULT_TOO_LONG;
    if (hdr_done) begin
      unique case (phase_q)
        lprd_pkg::PH_COUNT: begin
          if (shift_new[31:8] != 24'd0 || shift_new[7:0] > max_args_q) begin
            err   = 1'b1;
            fault = lprd_pkg::FAULT_TOO_MANY_ARGS;
          end else if (shift_new[7:0] == 8'd0) begin
            if (rem_dec != 16'd0) begin
              err   = 1'b1;
              fault = lprd_pkg::FAULT_TRAILING;
            end
          end else if (rem_dec < lprd_pkg::HdrBytes) begin
            err   = 1'b1;
            fault = lprd_pkg::FAULT_HDR_OVERRUN;
          end
        end
        lprd_pkg::PH_ARGLEN: begin
          if (shift_new[31:16] != 16'd0 || shift_new[15:0] > rem_dec) begin
            err   = 1'b1;
            fault = lprd_pkg::FAULT_BODY_OVERRUN;
          end else if (args_dec == 8'd0 && post != 16'd0) begin
            err   = 1'b1;
            fault = lprd_pkg::FAULT_TRAILING;
          end else if (args_dec != 8'd0 && post < lprd_pkg::HdrBytes) begin
            err   = 1'b1;
            fault = lprd_pkg::FAULT_HDR_OVERRUN;
          end
        end
        lprd_pkg::PH_LEN: begin
          if (shift_new[31:16] != 16'd0 || shift_new[15:0] > max_msg_q) begin
            err   = 1'b1;
            fault = lprd_pkg::FAULT_TOO_LONG;
          end else if (shift_new[15:0] < lprd_pkg::HdrBytes) begin
            err   = 1'b1;
            fault = lprd_pkg::FAULT_UNDER_MIN;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    rem_d       = rem_q;
    args_left_d = args_left_q;
    abl_d       = abl_q;
    cur_d       = cur_q;
    dead_d      = dead_q;

    if (step_i && !dead_q) begin
      if (phase_q == lprd_pkg::PH_BODY) begin
        rem_d = rem_dec;
        abl_d = body_abl;
        if (body_alast) begin
          cur_d   = cur_q + 8'd1;
          phase_d = (args_left_q != 8'd0) ? lprd_pkg::PH_ARGLEN : lprd_pkg::PH_LEN;
        end
      end else begin
        if (phase_q != lprd_pkg::PH_LEN) begin
          rem_d = rem_dec;
        end
        if (!hdr_done) begin
          cnt_d   = cnt_q + 2'd1;
          shift_d = shift_new;
        end else begin
          cnt_d   = 2'd0;
          shift_d = '0;
          if (err) begin
            dead_d = 1'b1;
          end else begin
            unique case (phase_q)
              lprd_pkg::PH_COUNT: begin
                cur_d = 8'd0;
                if (shift_new[7:0] == 8'd0) begin
                  phase_d = lprd_pkg::PH_LEN;
                end else begin
                  args_left_d = shift_new[7:0];
                  phase_d     = lprd_pkg::PH_ARGLEN;
                end
              end
              lprd_pkg::PH_ARGLEN: begin
                args_left_d = args_dec;
                if (shift_new[15:0] == 16'd0) begin
                  cur_d   = cur_q + 8'd1;
                  phase_d = (args_dec != 8'd0) ? lprd_pkg::PH_ARGLEN : lprd_pkg::PH_LEN;
                end else begin
                  abl_d   = shift_new[15:0];
                  phase_d = lprd_pkg::PH_BODY;
                end
              end
              lprd_pkg::PH_LEN: begin
                rem_d   = shift_new[15:0];
                phase_d = lprd_pkg::PH_COUNT;
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    res            = '0;
    res.kind       = lprd_pkg::KIND_ARG_BYTE;
    res.fault_code = lprd_pkg::FAULT_TOO_LONG;

    if (step_i && !dead_q) begin
      if (phase_q == lprd_pkg::PH_BODY) begin
        res.valid        = 1'b1;
        res.payload_byte = byte_i;
        res.arg_index    = cur_q;
        res.arg_last     = body_alast;
        res.message_last = body_alast && (args_left_q == 8'd0);
      end else if (hdr_done) begin
        if (err) begin
          res.valid      = 1'b1;
          res.kind       = lprd_pkg::KIND_ERROR;
          res.fault_code = fault;
        end else if (phase_q == lprd_pkg::PH_COUNT && shift_new[7:0] == 8'd0) begin
          res.valid        = 1'b1;
          res.kind         = lprd_pkg::KIND_EMPTY_REQ;
          res.message_last = 1'b1;
        end else if (phase_q == lprd_pkg::PH_ARGLEN && shift_new[15:0] == 16'd0) begin
          res.valid        = 1'b1;
          res.kind         = lprd_pkg::KIND_EMPTY_ARG;
          res.arg_index    = cur_q;
          res.arg_last     = 1'b1;
          res.message_last = (args_dec == 8'd0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lprd_pkg::PH_LEN;
      cnt_q       <= '0;
      shift_q     <= '0;
      rem_q       <= '0;
      args_left_q <= '0;
      abl_q       <= '0;
      cur_q       <= '0;
      dead_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      shift_q     <= shift_d;
      rem_q       <= rem_d;
      args_left_q <= args_left_d;
      abl_q       <= abl_d;
      cur_q       <= cur_d;
      dead_q      <= dead_d;
    end
  end

  assign res_o = res;

endmodule

// ===== src/lprd_out_stage.sv =====
// Result beat register of the deframer
`timescale 1ns / 1ps
module lprd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lprd_pkg::result_t res_i,
  input  logic              advance_i,
  output logic              can_load_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  logic              vld_q, vld_d;
  lprd_pkg::result_t res_q;
  logic              load;

  assign can_load_o = !vld_q || m_axis_tready;
  assign load       = advance_i && res_i.valid;
  assign vld_d      = can_load_o ? load : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {4'd0, res_q.fault_code, res_q.arg_last,
                          res_q.arg_index, res_q.payload_byte};
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.message_last;

endmodule

// ===== src/lprd_checker.sv =====
// Port-level checks of the deframer and their binding
`timescale 1ns / 1ps
`include "length_prefixed_request_deframer_macros.svh"
module lprd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic is_err;
  logic is_req;

  assign is_err = (m_axis_tuser == lprd_pkg::KIND_ERROR);
  assign is_req = (m_axis_tuser == lprd_pkg::KIND_EMPTY_REQ);

  `LPRD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")
  `LPRD_ASSERT_IMP(a_err_not_last, clk_i, rst_ni, m_axis_tvalid && is_err, !m_axis_tlast, "error beat marked last")
  `LPRD_ASSERT_NXT(a_dead_after_err, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && is_err, !m_axis_tvalid, "result beat after error")
  `LPRD_ASSERT_IMP(a_empty_req_last, clk_i, rst_ni, m_axis_tvalid && is_req, m_axis_tlast && (m_axis_tdata == 24'd0), "empty request beat malformed")

endmodule

bind length_prefixed_request_deframer lprd_checker u_lprd_checker (.*);

// ===== sim/length_prefixed_request_deframer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the length-prefixed request deframer: random requests in, checked items out
module length_prefixed_request_deframer_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBytes = 205;
  localparam int unsigned NumPhases  = 7;

  typedef struct packed {
    lprd_pkg::kind_e  kind;
    logic [7:0]       payload;
    logic [7:0]       arg_index;
    logic             arg_last;
    logic             msg_last;
    lprd_pkg::fault_e fault;
  } deframe_item_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_style_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = lprd_pkg::CFG_MAX_MSG;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic [15:0]      lim_msg   = lprd_pkg::MaxMsgReset;
  logic [7:0]       lim_args  = lprd_pkg::MaxArgsReset;
  lprd_pkg::phase_e ph        = lprd_pkg::PH_LEN;
  logic [1:0]       hdr_cnt   = '0;
  logic [31:0]      hdr_val   = '0;
  logic [15:0]      msg_left  = '0;
  logic [7:0]       args_left = '0;
  logic [15:0]      arg_left  = '0;
  logic [7:0]       cur_arg   = '0;
  logic             dead      = 1'b0;

  logic [7:0]    rx_stream [$];
  deframe_item_t due_items [$];

  logic [15:0] phase_msg_lim [NumPhases] = '{16'd4096, 16'd65535, 16'd4, 16'd60,
                                             16'd65535, 16'd13, 16'd300};
  logic [7:0]  phase_arg_lim [NumPhases] = '{8'd16, 8'd255, 8'd1, 8'd3, 8'd0, 8'd1, 8'd255};

  int unsigned bytes_queued = 0;
  int unsigned beats_out    = 0;
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned rx_hold      = 0;
  int unsigned rx_tick      = 0;
  bit          tx_bursty    = 1'b0;
  rx_style_e   rx_style     = RX_ALWAYS;

  length_prefixed_request_deframer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic deframe_item_t fault_item(input lprd_pkg::fault_e code);
    deframe_item_t f;
    f       = '0;
    f.kind  = lprd_pkg::KIND_ERROR;
    f.fault = code;
    dead    = 1'b1;
    return f;
  endfunction

  function automatic void close_arg();
    cur_arg = cur_arg + 8'd1;
    ph      = (args_left != 0) ? lprd_pkg::PH_ARGLEN : lprd_pkg::PH_LEN;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output deframe_item_t it);
    logic [31:0] v;
    logic [31:0] post;
    logic [7:0]  idx;
    logic        alast;
    it = '0;
    if (dead) return 1'b0;
    if (ph == lprd_pkg::PH_BODY) begin
      msg_left     = msg_left - 16'd1;
      arg_left     = arg_left - 16'd1;
      alast        = (arg_left == 0);
      idx          = cur_arg;
      if (alast) close_arg();
      it.kind      = lprd_pkg::KIND_ARG_BYTE;
      it.payload   = b;
      it.arg_index = idx;
      it.arg_last  = alast;
      it.msg_last  = alast && (args_left == 0);
      return 1'b1;
    end
    hdr_val = hdr_val | (32'(b) << (8 * hdr_cnt));
    if (ph != lprd_pkg::PH_LEN) msg_left = msg_left - 16'd1;
    if (hdr_cnt != 2'd3) begin
      hdr_cnt = hdr_cnt + 2'd1;
      return 1'b0;
    end
    hdr_cnt = '0;
    v       = hdr_val;
    hdr_val = '0;
    case (ph)
      lprd_pkg::PH_COUNT: begin
        if (v > lim_args) begin
          it = fault_item(lprd_pkg::FAULT_TOO_MANY_ARGS);
          return 1'b1;
        end
        cur_arg = '0;
        if (v == 0) begin
          if (msg_left != 0) begin
            it = fault_item(lprd_pkg::FAULT_TRAILING);
            return 1'b1;
          end
          ph          = lprd_pkg::PH_LEN;
          it.kind     = lprd_pkg::KIND_EMPTY_REQ;
          it.msg_last = 1'b1;
          return 1'b1;
        end
        if (msg_left < 16'd4) begin
          it = fault_item(lprd_pkg::FAULT_HDR_OVERRUN);
          return 1'b1;
        end
        args_left = v[7:0];
        ph        = lprd_pkg::PH_ARGLEN;
        return 1'b0;
      end
      lprd_pkg::PH_ARGLEN: begin
        if (v > {16'd0, msg_left}) begin
          it = fault_item(lprd_pkg::FAULT_BODY_OVERRUN);
          return 1'b1;
        end
        args_left = args_left - 8'd1;
        post      = {16'd0, msg_left} - v;
        if (args_left == 0 && post != 0) begin
          it = fault_item(lprd_pkg::FAULT_TRAILING);
          return 1'b1;
        end
        if (args_left != 0 && post < 4) begin
          it = fault_item(lprd_pkg::FAULT_HDR_OVERRUN);
          return 1'b1;
        end
        if (v == 0) begin
          idx = cur_arg;
          close_arg();
          it.kind      = lprd_pkg::KIND_EMPTY_ARG;
          it.arg_index = idx;
          it.arg_last  = 1'b1;
          it.msg_last  = (args_left == 0);
          return 1'b1;
        end
        arg_left = v[15:0];
        ph       = lprd_pkg::PH_BODY;
        return 1'b0;
      end
      default: begin
        if (v > {16'd0, lim_msg}) begin
          it = fault_item(lprd_pkg::FAULT_TOO_LONG);
          return 1'b1;
        end
        if (v < 4) begin
          it = fault_item(lprd_pkg::FAULT_UNDER_MIN);
          return 1'b1;
        end
        msg_left = v[15:0];
        ph       = lprd_pkg::PH_COUNT;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    rx_stream.insert(rx_stream.size(), b);
    bytes_queued++;
  endtask

  task automatic queue_u32(input logic [31:0] v);
    for (int k = 0; k < 4; k++) queue_byte(v[8*k +: 8]);
  endtask

  task automatic write_cfg(input lprd_pkg::cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == lprd_pkg::CFG_MAX_MSG) lim_msg = val;
    else lim_args = val[7:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (rx_stream.size() != 0 || s_axis_tvalid || due_items.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    deframe_item_t item;
    if (s_axis_tvalid && s_axis_tready) begin
      if (deframe_byte(s_axis_tdata, item)) due_items.insert(due_items.size(), item);
    end
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (rx_stream.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_stream.pop_front();
        if (tx_bursty) begin
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    deframe_item_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        if (due_items.size() == 0) begin
          $display("%0t ns: unexpected beat, expected none, actual kind %0d data %h", $time,
                   m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = due_items.pop_front();
          check_field("item_kind", 32'(want.kind), 32'(m_axis_tuser));
          check_field("payload_byte", 32'(want.payload), 32'(m_axis_tdata[7:0]));
          check_field("arg_index", 32'(want.arg_index), 32'(m_axis_tdata[15:8]));
          check_field("arg_last", 32'(want.arg_last), 32'(m_axis_tdata[16]));
          check_field("fault_code", 32'(want.fault), 32'(m_axis_tdata[19:17]));
          check_field("message_last", 32'(want.msg_last), 32'(m_axis_tlast));
        end
        if (beats_out % 500 == 150) rx_hold = 300;
      end
      rx_tick++;
      if (rx_hold != 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default:   m_axis_tready <= (rx_tick % 7 < 4);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int               target;
    int               n;
    int               n_max;
    int               room;
    int               body;
    int               left;
    int               len;
    int unsigned      variant;
    lprd_pkg::fault_e pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty request, then one empty argument and a one-byte argument
    queue_u32(4);
    queue_u32(0);
    queue_u32(13);
    queue_u32(2);
    queue_u32(0);
    queue_u32(1);
    queue_byte(8'hFF);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      write_cfg(lprd_pkg::CFG_MAX_MSG, phase_msg_lim[p]);
      write_cfg(lprd_pkg::CFG_MAX_ARGS, {8'd0, phase_arg_lim[p]});
      tx_bursty = 1'($urandom_range(0, 1));
      rx_style  = rx_style_e'($urandom_range(0, 2));
      target    = bytes_queued + PhaseBytes;
      while (bytes_queued < target) begin
        n_max = (lim_msg - 4) / 4;
        if (n_max > lim_args) n_max = lim_args;
        if (n_max > 12) n_max = 12;
        n    = $urandom_range(0, n_max);
        room = lim_msg - 4 - 4 * n;
        body = 0;
        if (n != 0) begin
          if (room <= 160 && $urandom_range(0, 7) == 0) body = room;
          else if (room >= 400 && $urandom_range(0, 39) == 0) body = $urandom_range(200, 400);
          else body = $urandom_range(0, (room < 20) ? room : 20);
        end
        queue_u32(4 + 4 * n + body);
        queue_u32(n);
        left = body;
        for (int k = 0; k < n; k++) begin
          if (k == n - 1) len = left;
          else if ($urandom_range(0, 2) == 0) len = 0;
          else len = $urandom_range(0, left);
          left -= len;
          queue_u32(len);
          repeat (len) queue_byte(8'($urandom_range(0, 255)));
        end
      end
      drain();
    end

    // one malformed request kills the block; trailing noise must be dropped
    write_cfg(lprd_pkg::CFG_MAX_MSG, 16'd100);
    write_cfg(lprd_pkg::CFG_MAX_ARGS, 16'd4);
    tx_bursty = 1'($urandom_range(0, 1));
    queue_u32(12);
    queue_u32(1);
    queue_u32(4);
    repeat (4) queue_byte(8'($urandom_range(0, 255)));
    pick    = lprd_pkg::fault_e'($urandom_range(lprd_pkg::FAULT_TOO_LONG,
                                                lprd_pkg::FAULT_TRAILING));
    variant = $urandom_range(0, 2);
    case (pick)
      lprd_pkg::FAULT_TOO_LONG: begin
        if (variant == 0) begin
          queue_u32(101);
        end else if (variant == 1) begin
          queue_u32(32'hFFFF_FFFF);
        end else begin
          drain();
          write_cfg(lprd_pkg::CFG_MAX_MSG, 16'($urandom_range(0, 3)));
          queue_u32(4);
        end
      end
      lprd_pkg::FAULT_UNDER_MIN: queue_u32($urandom_range(0, 3));
      lprd_pkg::FAULT_TOO_MANY_ARGS: begin
        queue_u32(20);
        queue_u32((variant == 0) ? 32'd5 : 32'h8000_0001);
      end
      lprd_pkg::FAULT_HDR_OVERRUN: begin
        if (variant == 0) begin
          queue_u32(6);
          queue_u32(2);
        end else begin
          queue_u32(16);
          queue_u32(2);
          queue_u32(4);
        end
      end
      lprd_pkg::FAULT_BODY_OVERRUN: begin
        queue_u32(12);
        queue_u32(1);
        queue_u32((variant == 0) ? 32'd5 : 32'h0001_0000);
      end
      default: begin
        if (variant == 0) begin
          queue_u32(6);
          queue_u32(0);
        end else begin
          queue_u32(14);
          queue_u32(1);
          queue_u32((variant == 1) ? 32'd2 : 32'd0);
        end
      end
    endcase
    repeat (16) queue_byte(8'($urandom_range(0, 255)));
    drain();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
